[hdl/sorted_fraction_table_core_assert.svh]
// ----------------------------------------------------------------------------
// Sorted fraction table assertion macros
// Clocked assertion shorthands shared by the table's RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_FRACTION_TABLE_CORE_ASSERT_SVH
`define SORTED_FRACTION_TABLE_CORE_ASSERT_SVH

// check a condition at every clock edge outside reset
`define SFT_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sorted_fraction_table_core: invariant violated");

// check that a trigger is followed by a condition in the next cycle
`define SFT_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("sorted_fraction_table_core: sequence violated");

`endif

[hdl/sft_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted fraction table package
// Sizes, item types and operation codes of the sorted fraction table.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 16;

  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KIND_W   = 2;
  localparam int THRESH_W = 15;
  localparam int COUNT_W  = 6;
  localparam int ENTRY_W  = 2 * VALUE_WIDTH;
  localparam int PROD_W   = 2 * VALUE_WIDTH;
  localparam int MAG_W    = VALUE_WIDTH + 1;
  localparam int CMP_W    = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILTER = 2'd2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd1;

  typedef struct packed {
    logic [KIND_W-1:0]             kind;
    logic signed [VALUE_WIDTH-1:0] numerator;
    logic signed [VALUE_WIDTH-1:0] denominator;
  } sft_in_t;

  typedef struct packed {
    logic                          status;
    logic [COUNT_W-1:0]            removed_count;
    logic                          entry_valid;
    logic signed [VALUE_WIDTH-1:0] out_numerator;
    logic signed [VALUE_WIDTH-1:0] out_denominator;
    logic                          last;
  } sft_out_t;

endpackage

[hdl/sorted_fraction_table_core.sv]
// ----------------------------------------------------------------------------
// Sorted fraction table core
// Bounded table of signed fractions kept in ascending cross-product order.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_item_i): one item per operation,
//     kind insert, remove equal fractions or filter readout.
//   out channel (out_valid_o / out_stall_i / out_item_o): one result for an
//     insert, remove or unused kind; one result per passing entry for a
//     filter, the final one marked last, or one empty result.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i): filter threshold,
//     always ready, write only while the block is idle.
// Operation: entries sit in a single-port memory with registered read, and one
//   signed multiplier serves both cross products. An insert reads each scanned
//   entry and forms both products, reads and writes each shifted entry, then
//   places the new one; a remove or filter reads and checks each stored entry.
//   Full-table inserts go straight to the result. in_stall_o is high from
//   acceptance until the last result is loaded into the output register.
// Reset empties the table (count 0, no clearing pass) and sets threshold 1.
// A stalled receiver holds the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module sorted_fraction_table_core
  import sft_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sft_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sft_out_t            out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [THRESH_W-1:0] cfg_data_i
);

  `include "sorted_fraction_table_core_assert.svh"

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_INS_RD  = 12'b000000000010,
    ST_INS_MA  = 12'b000000000100,
    ST_INS_MB  = 12'b000000001000,
    ST_SHF_RD  = 12'b000000010000,
    ST_SHF_WR  = 12'b000000100000,
    ST_PLACE   = 12'b000001000000,
    ST_RM_RD   = 12'b000010000000,
    ST_RM_CHK  = 12'b000100000000,
    ST_FLT_RD  = 12'b001000000000,
    ST_FLT_CHK = 12'b010000000000,
    ST_FINISH  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  keep_q, keep_d;
  logic [CNT_W-1:0]  sh_q, sh_d;
  logic [CNT_W-1:0]  rm_q, rm_d;
  logic [KIND_W-1:0] op_q, op_d;
  logic              full_q, full_d;
  logic              pend_vld_q, pend_vld_d;
  logic              out_valid_q, out_valid_d;
  logic [THRESH_W-1:0] thr_q;

  logic signed [VALUE_WIDTH-1:0] yn_q, yn_d, yd_q, yd_d;
  logic [ENTRY_W-1:0]            pend_q, pend_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  sft_out_t                      out_item_q;

  logic [ENTRY_W-1:0] mem_q [CAPACITY];
  logic [ENTRY_W-1:0] rd_q;
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic signed [VALUE_WIDTH-1:0] rd_num, rd_den;
  logic signed [VALUE_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]      product;
  logic                          less;
  logic [MAG_W-1:0]              mag;
  logic                          flt_pass;
  logic                          out_free;
  logic                          emit;
  sft_out_t                      emit_item;
  logic [CNT_W-1:0]              idx_inc, sh_dec, keep_inc;

  assign rd_num  = rd_q[ENTRY_W-1:VALUE_WIDTH];
  assign rd_den  = rd_q[VALUE_WIDTH-1:0];
  assign product = mul_a * mul_b;
  assign less    = prod_q < product;
  assign mag     = rd_num[VALUE_WIDTH-1] ? MAG_W'(-{rd_num[VALUE_WIDTH-1], rd_num})
                                         : MAG_W'({1'b0, rd_num});
  assign flt_pass = CMP_W'(mag) > CMP_W'(thr_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_inc  = CNT_W'(idx_q + 1'b1);
  assign sh_dec   = CNT_W'(sh_q - 1'b1);
  assign keep_inc = CNT_W'(keep_q + 1'b1);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    keep_d     = keep_q;
    sh_d       = sh_q;
    rm_d       = rm_q;
    op_d       = op_q;
    full_d     = full_q;
    pend_vld_d = pend_vld_q;
    yn_d       = yn_q;
    yd_d       = yd_q;
    pend_d     = pend_q;
    prod_d     = prod_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q[ADDR_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx_q[ADDR_W-1:0];
    wr_data    = rd_q;
    mul_a      = rd_num;
    mul_b      = yd_q;
    emit       = 1'b0;
    emit_item  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d       = in_item_i.kind;
          yn_d       = in_item_i.numerator;
          yd_d       = in_item_i.denominator;
          idx_d      = '0;
          keep_d     = '0;
          pend_vld_d = 1'b0;
          full_d     = 1'b0;
          state_d    = ST_FINISH;
          if (in_item_i.kind == KIND_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              full_d = 1'b1;
            end else if (count_q == '0) begin
              state_d = ST_PLACE;
            end else begin
              state_d = ST_INS_RD;
            end
          end else if (in_item_i.kind == KIND_REMOVE) begin
            rm_d = '0;
            if (count_q != '0) begin
              state_d = ST_RM_RD;
            end
          end else if (in_item_i.kind == KIND_FILTER) begin
            if (count_q != '0) begin
              state_d = ST_FLT_RD;
            end
          end
        end
      end
      ST_INS_RD: begin
        rd_en   = 1'b1;
        state_d = ST_INS_MA;
      end
      ST_INS_MA: begin
        mul_a   = rd_num;
        mul_b   = yd_q;
        prod_d  = product;
        state_d = ST_INS_MB;
      end
      ST_INS_MB: begin
        mul_a = yn_q;
        mul_b = rd_den;
        if (!less) begin
          sh_d    = count_q;
          state_d = ST_SHF_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = (idx_inc == count_q) ? ST_PLACE : ST_INS_RD;
        end
      end
      ST_SHF_RD: begin
        rd_en   = 1'b1;
        rd_addr = sh_dec[ADDR_W-1:0];
        state_d = ST_SHF_WR;
      end
      ST_SHF_WR: begin
        wr_en   = 1'b1;
        wr_addr = sh_q[ADDR_W-1:0];
        sh_d    = sh_dec;
        state_d = (sh_dec == idx_q) ? ST_PLACE : ST_SHF_RD;
      end
      ST_PLACE: begin
        wr_en   = 1'b1;
        wr_data = {yn_q, yd_q};
        count_d = CNT_W'(count_q + 1'b1);
        state_d = ST_FINISH;
      end
      ST_RM_RD: begin
        rd_en   = 1'b1;
        state_d = ST_RM_CHK;
      end
      ST_RM_CHK: begin
        if (rd_q != {yn_q, yd_q}) begin
          wr_en   = 1'b1;
          wr_addr = keep_q[ADDR_W-1:0];
          keep_d  = keep_inc;
        end
        idx_d = idx_inc;
        if (idx_inc == count_q) begin
          count_d = keep_d;
          rm_d    = CNT_W'(count_q - keep_d);
          state_d = ST_FINISH;
        end else begin
          state_d = ST_RM_RD;
        end
      end
      ST_FLT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_FLT_CHK;
      end
      ST_FLT_CHK: begin
        if (!(flt_pass && pend_vld_q && !out_free)) begin
          if (flt_pass) begin
            if (pend_vld_q) begin
              emit                      = 1'b1;
              emit_item.entry_valid     = 1'b1;
              emit_item.out_numerator   = pend_q[ENTRY_W-1:VALUE_WIDTH];
              emit_item.out_denominator = pend_q[VALUE_WIDTH-1:0];
            end
            pend_d     = rd_q;
            pend_vld_d = 1'b1;
          end
          idx_d   = idx_inc;
          state_d = (idx_inc == count_q) ? ST_FINISH : ST_FLT_RD;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_item.last = 1'b1;
          if (op_q == KIND_INSERT) begin
            emit_item.status = full_q;
          end else if (op_q == KIND_REMOVE) begin
            emit_item.removed_count = (32'(rm_q) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                              : COUNT_W'(rm_q);
          end else if (op_q == KIND_FILTER && pend_vld_q) begin
            emit_item.entry_valid     = 1'b1;
            emit_item.out_numerator   = pend_q[ENTRY_W-1:VALUE_WIDTH];
            emit_item.out_denominator = pend_q[VALUE_WIDTH-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      keep_q      <= '0;
      sh_q        <= '0;
      rm_q        <= '0;
      op_q        <= KIND_INSERT;
      full_q      <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= THRESH_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      keep_q      <= keep_d;
      sh_q        <= sh_d;
      rm_q        <= rm_d;
      op_q        <= op_d;
      full_q      <= full_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    yn_q   <= yn_d;
    yd_q   <= yd_d;
    pend_q <= pend_d;
    prod_q <= prod_d;
    if (emit) begin
      out_item_q <= emit_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  `SFT_ASSERT_NOW(a_count_bound, count_q <= CNT_W'(CAPACITY))
  `SFT_ASSERT_NOW(a_shift_above_pos,
                  (state_q == ST_SHF_RD || state_q == ST_SHF_WR) -> (sh_q > idx_q))
  `SFT_ASSERT_NOW(a_keep_behind_scan, (state_q == ST_RM_CHK) -> (keep_q <= idx_q))
  `SFT_ASSERT_NOW(a_write_in_table, wr_en -> (32'(wr_addr) <= 32'(count_q)))
  `SFT_ASSERT_NEXT(a_filter_waits,
                   state_q == ST_FLT_CHK && flt_pass && pend_vld_q && !out_free,
                   state_q == ST_FLT_CHK)

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Sorted fraction table core testbench
// Drives insert, remove, filter and unused-kind items into the table through
// the stall handshake, predicts every result with a local copy of the sorted
// table and threshold, and checks each result field by field in order. Covers
// the empty table, signed extremes, zero denominators, a full table under
// receiver hold-off, mass removal and several filter thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sft_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  sft_in_t             in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  sft_out_t            out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [THRESH_W-1:0] cfg_data_i;

  logic signed [VALUE_WIDTH-1:0] tbl_num [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] tbl_den [CAPACITY];
  int                            tbl_count;
  logic [THRESH_W-1:0]           cur_threshold;
  sft_out_t                      expected_results [$];

  int src_gap_pct;
  int sink_stall_pct;
  int hold_cycles;
  int mismatch_count;
  int items_sent;
  int results_checked;
  int full_drops;
  int cfg_writes;

  sorted_fraction_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #25_000_000;
    $display("sorted_fraction_table_core: mismatch");
    $finish;
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic bit frac_less(input logic signed [VALUE_WIDTH-1:0] xn, xd, yn, yd);
    longint lhs;
    longint rhs;
    lhs = longint'(xn) * longint'(yd);
    rhs = longint'(yn) * longint'(xd);
    return lhs < rhs;
  endfunction

  function automatic void queue_result(input sft_out_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void table_update(input sft_in_t it);
    sft_out_t r;
    int       pos;
    int       keep;
    int       gone;
    int       hits;
    longint   mag;
    r = '0;
    r.last = 1'b1;
    case (it.kind)
      KIND_INSERT: begin
        if (tbl_count >= CAPACITY) begin
          r.status = 1'b1;
          full_drops++;
        end else begin
          pos = tbl_count;
          for (int i = 0; i < tbl_count; i++) begin
            if (!frac_less(tbl_num[i], tbl_den[i], it.numerator, it.denominator)) begin
              pos = i;
              break;
            end
          end
          for (int i = tbl_count; i > pos; i--) begin
            tbl_num[i] = tbl_num[i-1];
            tbl_den[i] = tbl_den[i-1];
          end
          tbl_num[pos] = it.numerator;
          tbl_den[pos] = it.denominator;
          tbl_count++;
        end
        queue_result(r);
      end
      KIND_REMOVE: begin
        keep = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_num[i] == it.numerator && tbl_den[i] == it.denominator) continue;
          tbl_num[keep] = tbl_num[i];
          tbl_den[keep] = tbl_den[i];
          keep++;
        end
        gone = tbl_count - keep;
        tbl_count = keep;
        r.removed_count = COUNT_W'((gone > COUNT_MAX) ? COUNT_MAX : gone);
        queue_result(r);
      end
      KIND_FILTER: begin
        hits = 0;
        for (int i = 0; i < tbl_count; i++) begin
          mag = longint'(tbl_num[i]);
          if (mag < 0) mag = -mag;
          if (mag > longint'(cur_threshold)) begin
            r = '0;
            r.entry_valid = 1'b1;
            r.out_numerator = tbl_num[i];
            r.out_denominator = tbl_den[i];
            queue_result(r);
            hits++;
          end
        end
        if (hits == 0) begin
          r = '0;
          r.last = 1'b1;
          queue_result(r);
        end else begin
          expected_results[expected_results.size()-1].last = 1'b1;
        end
      end
      default: queue_result(r);
    endcase
  endfunction

  task automatic check_result(input sft_out_t got);
    sft_out_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result at %0t: %p", $realtime, got);
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.status !== want.status || got.removed_count !== want.removed_count ||
        got.entry_valid !== want.entry_valid || got.out_numerator !== want.out_numerator ||
        got.out_denominator !== want.out_denominator || got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("bad result at %0t: expected %p, got %p", $realtime, want, got);
    end
  endtask

  initial begin : result_sink
    int stall_run;
    stall_run = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_item_o);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        if (stall_run == 0) stall_run = pick_gap(sink_stall_pct);
        if (stall_run > 0) begin
          stall_run--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  task automatic send_item(input sft_in_t it);
    int gap;
    gap = pick_gap(src_gap_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    table_update(it);
    items_sent++;
  endtask

  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic signed [VALUE_WIDTH-1:0] num, den);
    sft_in_t it;
    it.kind = kind;
    it.numerator = num;
    it.denominator = den;
    send_item(it);
  endtask

  // hold the input idle until every expected result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_threshold = value;
    cfg_writes++;
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] rand_value();
    case ($urandom_range(3))
      0: return VALUE_WIDTH'($urandom_range(8)) - VALUE_WIDTH'(4);
      1: begin
        case ($urandom_range(3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic sft_in_t random_op();
    sft_in_t it;
    int      pick;
    int      idx;
    pick = $urandom_range(99);
    it.numerator = rand_value();
    it.denominator = rand_value();
    if (pick < 55) it.kind = KIND_INSERT;
    else if (pick < 75) it.kind = KIND_REMOVE;
    else if (pick < 95) it.kind = KIND_FILTER;
    else it.kind = KIND_UNUSED;
    // reuse a stored fraction so removes hit and duplicates pile up
    if ((it.kind == KIND_REMOVE || it.kind == KIND_INSERT) && tbl_count > 0 &&
        $urandom_range(99) < ((it.kind == KIND_REMOVE) ? 75 : 25)) begin
      idx = $urandom_range(tbl_count - 1);
      it.numerator = tbl_num[idx];
      it.denominator = tbl_den[idx];
    end
    return it;
  endfunction

  task automatic test_empty_table();
    src_gap_pct = 20;
    sink_stall_pct = 20;
    send_op(KIND_FILTER, VAL_MAX, VAL_MAX);
    send_op(KIND_REMOVE, '0, '0);
    send_op(KIND_UNUSED, VAL_MIN, VAL_MIN);
    drain();
  endtask

  task automatic test_directed_ops();
    send_op(KIND_INSERT, 16'sd1, 16'sd2);
    send_op(KIND_INSERT, VAL_MIN, 16'sd1);
    send_op(KIND_INSERT, VAL_MAX, VAL_MIN);
    send_op(KIND_INSERT, 16'sd3, '0);
    send_op(KIND_INSERT, '0, '0);
    send_op(KIND_INSERT, 16'sd1, 16'sd2);
    send_op(KIND_INSERT, -16'sd1, -16'sd2);
    send_op(KIND_INSERT, VAL_MAX, VAL_MAX);
    send_op(KIND_INSERT, VAL_MIN, VAL_MIN);
    send_op(KIND_FILTER, '0, '0);
    send_op(KIND_REMOVE, 16'sd1, 16'sd2);
    send_op(KIND_REMOVE, -16'sd1, -16'sd2);
    send_op(KIND_REMOVE, 16'sd7, 16'sd7);
    send_op(KIND_UNUSED, VAL_MAX, VAL_MIN);
    send_op(KIND_FILTER, '1, '1);
    drain();
  endtask

  task automatic test_fill_under_backpressure();
    logic signed [VALUE_WIDTH-1:0] rep_num;
    logic signed [VALUE_WIDTH-1:0] rep_den;
    write_threshold('0);
    rep_num = rand_value();
    rep_den = rand_value();
    hold_cycles = 300;
    while (tbl_count < CAPACITY) begin
      if ($urandom_range(2) == 0) send_op(KIND_INSERT, rep_num, rep_den);
      else send_op(KIND_INSERT, rand_value(), rand_value());
    end
    send_op(KIND_INSERT, rand_value(), rand_value());
    send_op(KIND_INSERT, rep_num, rep_den);
    send_op(KIND_FILTER, rand_value(), rand_value());
    send_op(KIND_REMOVE, rep_num, rep_den);
    send_op(KIND_FILTER, rand_value(), rand_value());
    drain();
  endtask

  task automatic test_random_phase(input logic [THRESH_W-1:0] threshold,
                                   input int src_pct, input int sink_pct, input int count);
    write_threshold(threshold);
    src_gap_pct = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) send_item(random_op());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    hold_cycles = 0;
    mismatch_count = 0;
    items_sent = 0;
    results_checked = 0;
    full_drops = 0;
    cfg_writes = 0;
    tbl_count = 0;
    cur_threshold = THRESH_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_directed_ops();
    test_fill_under_backpressure();
    test_random_phase(VAL_MAX[THRESH_W-1:0], 0, 0, 30);
    test_random_phase(THRESH_W'($urandom_range(40)), 30, 30, 30);
    test_random_phase(THRESH_RESET, 60, 10, 30);
    test_random_phase(THRESH_W'($urandom), 10, 60, 30);

    drain();
    repeat (120) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("covered %0d items and %0d results, %0d inserts dropped on a full table,",
             items_sent, results_checked, full_drops);
    $display("over %0d threshold writes; %0d bad results", cfg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("sorted_fraction_table_core: match");
    end else begin
      $display("sorted_fraction_table_core: mismatch");
    end
    $finish;
  end

endmodule

[sorted_fraction_table_core.f]
+incdir+hdl
hdl/sft_pkg.sv
hdl/sorted_fraction_table_core.sv
sim/tb.sv
